@@ rtl/alc_pkg.sv @@
// Shared types, codes and decode functions for the alarm lifecycle block.
// No dependencies; the interfaces and the top level import this package.
package alc_pkg;

  localparam int OP_BITS     = 4;
  localparam int STATE_BITS  = 3;
  localparam int STATUS_BITS = 3;
  localparam int OCC_BITS    = 16;

  typedef logic [OP_BITS-1:0]     op_t;
  typedef logic [STATE_BITS-1:0]  state_t;
  typedef logic [STATUS_BITS-1:0] status_t;
  typedef logic [OCC_BITS-1:0]    occ_t;

  localparam op_t OP_ACTIVATE    = 4'd0;
  localparam op_t OP_ACKNOWLEDGE = 4'd1;
  localparam op_t OP_CLEAR       = 4'd2;
  localparam op_t OP_CLOSE       = 4'd3;
  localparam op_t OP_SHELVE      = 4'd4;
  localparam op_t OP_UNSHELVE    = 4'd5;
  localparam op_t OP_SUPPRESS    = 4'd6;
  localparam op_t OP_UNSUPPRESS  = 4'd7;
  localparam op_t OP_REACTIVATE  = 4'd8;

  localparam state_t ST_NEW        = 3'd0;
  localparam state_t ST_ACTIVE     = 3'd1;
  localparam state_t ST_ACKED      = 3'd2;
  localparam state_t ST_CLEARED    = 3'd3;
  localparam state_t ST_CLOSED     = 3'd4;
  localparam state_t ST_SHELVED    = 3'd5;
  localparam state_t ST_SUPPRESSED = 3'd6;

  localparam status_t STS_OK          = 3'd0;
  localparam status_t STS_INVALID     = 3'd1;
  localparam status_t STS_NO_ACTOR    = 3'd2;
  localparam status_t STS_ACK_NOT_REQ = 3'd3;
  localparam status_t STS_CLOSED      = 3'd4;

  function automatic logic is_live(state_t s);
    return (s == ST_NEW) || (s == ST_ACTIVE) || (s == ST_ACKED);
  endfunction

  function automatic logic is_legal(op_t op, state_t s);
    logic ok;
    case (op)
      OP_ACTIVATE:    ok = (s == ST_NEW);
      OP_ACKNOWLEDGE: ok = (s == ST_NEW) || (s == ST_ACTIVE);
      OP_CLEAR:       ok = is_live(s);
      OP_CLOSE:       ok = (s == ST_CLEARED);
      OP_SHELVE:      ok = is_live(s);
      OP_UNSHELVE:    ok = (s == ST_SHELVED);
      OP_SUPPRESS:    ok = is_live(s);
      OP_UNSUPPRESS:  ok = (s == ST_SUPPRESSED);
      OP_REACTIVATE:  ok = (s == ST_CLEARED);
      default:        ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic state_t target_state(op_t op);
    state_t t;
    case (op)
      OP_ACKNOWLEDGE: t = ST_ACKED;
      OP_CLEAR:       t = ST_CLEARED;
      OP_CLOSE:       t = ST_CLOSED;
      OP_SHELVE:      t = ST_SHELVED;
      OP_SUPPRESS:    t = ST_SUPPRESSED;
      default:        t = ST_ACTIVE;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/alc_if.sv @@
// Valid/ready channel interfaces for requests, results and the configuration write.
// Depends on alc_pkg for the field types.
interface alc_in_if #(
  parameter int TIME_BITS  = 48,
  parameter int ACTOR_BITS = 16
) ();
  import alc_pkg::*;
  logic                  valid;
  logic                  ready;
  op_t                   operation;
  logic [TIME_BITS-1:0]  request_time;
  logic [TIME_BITS-1:0]  current_time;
  logic [ACTOR_BITS-1:0] actor_id;
  logic                  actor_required;

  modport source(output valid, operation, request_time, current_time, actor_id,
                 actor_required, input ready);
  modport sink(input valid, operation, request_time, current_time, actor_id,
               actor_required, output ready);
endinterface

interface alc_out_if #(
  parameter int TIME_BITS  = 48,
  parameter int ACTOR_BITS = 16
) ();
  import alc_pkg::*;
  logic                  valid;
  logic                  ready;
  status_t               status;
  state_t                state_before;
  state_t                state_after;
  logic [TIME_BITS-1:0]  applied_time;
  logic [TIME_BITS-1:0]  activation_stamp;
  logic [TIME_BITS-1:0]  acknowledge_stamp;
  logic [TIME_BITS-1:0]  clear_stamp;
  logic [TIME_BITS-1:0]  close_stamp;
  logic [ACTOR_BITS-1:0] acknowledged_by_id;
  logic [ACTOR_BITS-1:0] closed_by_id;
  occ_t                  occurrence_total;

  modport source(output valid, status, state_before, state_after, applied_time,
                 activation_stamp, acknowledge_stamp, clear_stamp, close_stamp,
                 acknowledged_by_id, closed_by_id, occurrence_total, input ready);
  modport sink(input valid, status, state_before, state_after, applied_time,
               activation_stamp, acknowledge_stamp, clear_stamp, close_stamp,
               acknowledged_by_id, closed_by_id, occurrence_total, output ready);
endinterface

interface alc_cfg_if ();
  logic valid;
  logic ready;
  logic ack_required;

  modport source(output valid, ack_required, input ready);
  modport sink(input valid, ack_required, output ready);
endinterface

@@ rtl/alarm_lifecycle_fsm.sv @@
// Top level of the alarm lifecycle block: one alarm record and its transition checks.
// Depends on alc_pkg and the channel interfaces in alc_if.sv.
//
// Each request is captured in an input register, then checked and applied when
// the output register is empty or its result is being taken; its result is then
// loaded into the output register. One request is accepted in every cycle while
// results are taken. The record fields of a result are read straight from the
// record registers, which change only when the next result is loaded. The
// configuration bit is always accepted.
module alarm_lifecycle_fsm #(
  parameter int TIME_BITS  = 48,
  parameter int ACTOR_BITS = 16
) (
  input logic    clk,
  input logic    rst_n,
  alc_in_if.sink   in_chan,
  alc_out_if.source out_chan,
  alc_cfg_if.sink  cfg_chan
);
  import alc_pkg::*;

  logic                  ack_req_r;

  logic                  req_v_r;
  op_t                   op_r;
  logic [TIME_BITS-1:0]  req_time_r;
  logic [TIME_BITS-1:0]  cur_time_r;
  logic [ACTOR_BITS-1:0] actor_r;
  logic                  need_actor_r;

  state_t                state_r;
  logic [TIME_BITS-1:0]  act_time_r;
  logic [TIME_BITS-1:0]  ack_time_r;
  logic [TIME_BITS-1:0]  clr_time_r;
  logic [TIME_BITS-1:0]  cls_time_r;
  logic [ACTOR_BITS-1:0] acker_r;
  logic [ACTOR_BITS-1:0] closer_r;
  occ_t                  occ_r;

  logic                  out_v_r;
  status_t               status_r;
  state_t                before_r;
  logic [TIME_BITS-1:0]  applied_r;

  logic                  advance;
  status_t               status_nxt;
  logic [TIME_BITS-1:0]  stamp_nxt;

  assign advance       = req_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !req_v_r || advance;
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    if (state_r == ST_CLOSED) begin
      status_nxt = STS_CLOSED;
    end else if (need_actor_r && (actor_r == '0)) begin
      status_nxt = STS_NO_ACTOR;
    end else if ((op_r == OP_ACKNOWLEDGE) && !ack_req_r) begin
      status_nxt = STS_ACK_NOT_REQ;
    end else if (!is_legal(op_r, state_r)) begin
      status_nxt = STS_INVALID;
    end else begin
      status_nxt = STS_OK;
    end
    stamp_nxt = (req_time_r != '0) ? req_time_r : cur_time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_req_r <= 1'b1;
    end else if (cfg_chan.valid) begin
      ack_req_r <= cfg_chan.ack_required;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      req_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      op_r         <= in_chan.operation;
      req_time_r   <= in_chan.request_time;
      cur_time_r   <= in_chan.current_time;
      actor_r      <= in_chan.actor_id;
      need_actor_r <= in_chan.actor_required;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_r  <= status_nxt;
      before_r  <= state_r;
      applied_r <= (status_nxt == STS_OK) ? stamp_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_NEW;
      act_time_r <= '0;
      ack_time_r <= '0;
      clr_time_r <= '0;
      cls_time_r <= '0;
      acker_r    <= '0;
      closer_r   <= '0;
      occ_r      <= '0;
    end else if (advance && (status_nxt == STS_OK)) begin
      state_r <= target_state(op_r);
      case (op_r)
        OP_ACTIVATE, OP_UNSHELVE, OP_UNSUPPRESS: begin
          act_time_r <= stamp_nxt;
        end
        OP_ACKNOWLEDGE: begin
          ack_time_r <= stamp_nxt;
          acker_r    <= actor_r;
        end
        OP_CLEAR: begin
          clr_time_r <= stamp_nxt;
        end
        OP_CLOSE: begin
          cls_time_r <= stamp_nxt;
          closer_r   <= actor_r;
        end
        OP_REACTIVATE: begin
          act_time_r <= stamp_nxt;
          if (occ_r != '1) begin
            occ_r <= occ_r + occ_t'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_chan.valid              = out_v_r;
  assign out_chan.status             = status_r;
  assign out_chan.state_before       = before_r;
  assign out_chan.state_after        = state_r;
  assign out_chan.applied_time       = applied_r;
  assign out_chan.activation_stamp   = act_time_r;
  assign out_chan.acknowledge_stamp  = ack_time_r;
  assign out_chan.clear_stamp        = clr_time_r;
  assign out_chan.close_stamp        = cls_time_r;
  assign out_chan.acknowledged_by_id = acker_r;
  assign out_chan.closed_by_id       = closer_r;
  assign out_chan.occurrence_total   = occ_r;

endmodule

@@ bench/alarm_lifecycle_fsm_tb.sv @@
// Self-checking bench for alarm_lifecycle_fsm: directed lifecycle walks, random
// transition requests, repeated reactivations and the final close.
// Depends on alc_pkg, the channel interfaces in alc_if.sv and the block itself.
module alarm_lifecycle_fsm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alc_pkg::*;

  localparam int TW = 48;
  localparam int AW = 16;
  localparam int PHASE_ITEMS = 220;

  typedef struct packed {
    op_t           operation;
    logic [TW-1:0] request_time;
    logic [TW-1:0] current_time;
    logic [AW-1:0] actor_id;
    logic          actor_required;
  } alarm_req_t;

  typedef struct packed {
    state_t        life;
    logic [TW-1:0] act_t;
    logic [TW-1:0] ack_t;
    logic [TW-1:0] clr_t;
    logic [TW-1:0] cls_t;
    logic [AW-1:0] acker;
    logic [AW-1:0] closer;
    occ_t          occ;
  } alarm_rec_t;

  typedef struct packed {
    status_t       status;
    state_t        state_before;
    state_t        state_after;
    logic [TW-1:0] applied_time;
    logic [TW-1:0] activation_stamp;
    logic [TW-1:0] acknowledge_stamp;
    logic [TW-1:0] clear_stamp;
    logic [TW-1:0] close_stamp;
    logic [AW-1:0] acknowledged_by_id;
    logic [AW-1:0] closed_by_id;
    occ_t          occurrence_total;
  } alarm_res_t;

  logic clk;
  logic rst_n;

  alc_in_if #(.TIME_BITS(TW), .ACTOR_BITS(AW)) in_if ();
  alc_out_if #(.TIME_BITS(TW), .ACTOR_BITS(AW)) out_if ();
  alc_cfg_if cfg_if ();

  alarm_lifecycle_fsm #(.TIME_BITS(TW), .ACTOR_BITS(AW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  alarm_req_t pending_reqs[$];
  alarm_res_t expected_results[$];
  alarm_rec_t gen_rec;
  alarm_rec_t chk_rec;
  logic       gen_ack;
  logic       chk_ack;
  alarm_req_t next_req;
  alarm_req_t seen_req;
  alarm_res_t want_res;
  logic       in_taken;
  int         items_queued;
  int         items_accepted;
  int         mismatches;
  int         src_idle_pct;
  int         snk_stall_pct;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic alarm_res_t step_alarm(inout alarm_rec_t rec, input logic ack_req,
                                            input alarm_req_t rq);
    alarm_res_t    res;
    logic          move_ok;
    logic [TW-1:0] stamp;
    res = '0;
    res.state_before = rec.life;
    case (rq.operation)
      OP_ACTIVATE:                      move_ok = (rec.life == ST_NEW);
      OP_ACKNOWLEDGE:                   move_ok = rec.life inside {ST_NEW, ST_ACTIVE};
      OP_CLEAR, OP_SHELVE, OP_SUPPRESS: move_ok = rec.life inside {ST_NEW, ST_ACTIVE, ST_ACKED};
      OP_CLOSE, OP_REACTIVATE:          move_ok = (rec.life == ST_CLEARED);
      OP_UNSHELVE:                      move_ok = (rec.life == ST_SHELVED);
      OP_UNSUPPRESS:                    move_ok = (rec.life == ST_SUPPRESSED);
      default:                          move_ok = 1'b0;
    endcase
    if (rec.life == ST_CLOSED) res.status = STS_CLOSED;
    else if (rq.actor_required && rq.actor_id == '0) res.status = STS_NO_ACTOR;
    else if (rq.operation == OP_ACKNOWLEDGE && !ack_req) res.status = STS_ACK_NOT_REQ;
    else if (!move_ok) res.status = STS_INVALID;
    else res.status = STS_OK;
    if (res.status == STS_OK) begin
      stamp = (rq.request_time != '0) ? rq.request_time : rq.current_time;
      res.applied_time = stamp;
      case (rq.operation)
        OP_ACKNOWLEDGE: begin
          rec.life = ST_ACKED;
          rec.ack_t = stamp;
          rec.acker = rq.actor_id;
        end
        OP_CLEAR: begin
          rec.life = ST_CLEARED;
          rec.clr_t = stamp;
        end
        OP_CLOSE: begin
          rec.life = ST_CLOSED;
          rec.cls_t = stamp;
          rec.closer = rq.actor_id;
        end
        OP_SHELVE:   rec.life = ST_SHELVED;
        OP_SUPPRESS: rec.life = ST_SUPPRESSED;
        OP_REACTIVATE: begin
          rec.life = ST_ACTIVE;
          rec.act_t = stamp;
          if (rec.occ != '1) rec.occ = rec.occ + occ_t'(1);
        end
        default: begin
          rec.life = ST_ACTIVE;
          rec.act_t = stamp;
        end
      endcase
    end
    res.state_after = rec.life;
    res.activation_stamp = rec.act_t;
    res.acknowledge_stamp = rec.ack_t;
    res.clear_stamp = rec.clr_t;
    res.close_stamp = rec.cls_t;
    res.acknowledged_by_id = rec.acker;
    res.closed_by_id = rec.closer;
    res.occurrence_total = rec.occ;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
  endtask

  function automatic logic [TW-1:0] rand_time();
    logic [63:0] raw;
    int          pick;
    pick = $urandom_range(99);
    raw = {$urandom, $urandom};
    if (pick < 10) return '0;
    if (pick < 15) return '1;
    return raw[TW-1:0];
  endfunction

  function automatic logic [AW-1:0] rand_actor();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 15) return '1;
    return AW'($urandom);
  endfunction

  task automatic queue_request(input alarm_req_t rq);
    alarm_res_t ignored;
    ignored = step_alarm(gen_rec, gen_ack, rq);
    pending_reqs.push_back(rq);
    items_queued++;
  endtask

  task automatic push_op(input op_t op, input logic [TW-1:0] req_t, input logic [TW-1:0] cur_t,
                         input logic [AW-1:0] actor, input logic need_actor);
    alarm_req_t rq;
    rq.operation = op;
    rq.request_time = req_t;
    rq.current_time = cur_t;
    rq.actor_id = actor;
    rq.actor_required = need_actor;
    queue_request(rq);
  endtask

  // The alarm may be closed only once per run, so a close that would succeed is
  // always turned into a missing-actor request.
  function automatic alarm_req_t random_request(input logic well_formed);
    alarm_req_t rq;
    alarm_rec_t trial;
    alarm_res_t res;
    for (int tries = 0; tries < 32; tries++) begin
      rq.operation = well_formed ? op_t'($urandom_range(8)) : op_t'($urandom_range(15));
      rq.request_time = rand_time();
      rq.current_time = rand_time();
      rq.actor_id = rand_actor();
      rq.actor_required = 1'($urandom_range(1));
      trial = gen_rec;
      res = step_alarm(trial, gen_ack, rq);
      if (!well_formed || res.status == STS_OK) break;
    end
    if (res.status == STS_OK && rq.operation == OP_CLOSE) begin
      rq.actor_required = 1'b1;
      rq.actor_id = '0;
    end
    return rq;
  endfunction

  task automatic route_to_cleared();
    op_t op;
    while (gen_rec.life != ST_CLEARED) begin
      case (gen_rec.life)
        ST_SHELVED:    op = OP_UNSHELVE;
        ST_SUPPRESSED: op = OP_UNSUPPRESS;
        default:       op = OP_CLEAR;
      endcase
      push_op(op, rand_time(), rand_time(), rand_actor(), 1'b0);
    end
  endtask

  task automatic write_ack_required(input logic value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.ack_required <= value;
    gen_ack = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (items_accepted != items_queued || expected_results.size() != 0);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1:       begin src_idle_pct = 46; snk_stall_pct = 0;  end
      2:       begin src_idle_pct = 0;  snk_stall_pct = 46; end
      3:       begin src_idle_pct = 28; snk_stall_pct = 28; end
      default: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
    endcase
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      if (!in_if.valid || in_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_if.valid <= 1'b1;
          in_if.operation <= next_req.operation;
          in_if.request_time <= next_req.request_time;
          in_if.current_time <= next_req.current_time;
          in_if.actor_id <= next_req.actor_id;
          in_if.actor_required <= next_req.actor_required;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) chk_ack = cfg_if.ack_required;
      if (out_if.valid === 1'b1 && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result item with no request outstanding");
        end else begin
          want_res = expected_results.pop_front();
          check_field("status", 64'(out_if.status), 64'(want_res.status));
          check_field("state_before", 64'(out_if.state_before),
                      64'(want_res.state_before));
          check_field("state_after", 64'(out_if.state_after), 64'(want_res.state_after));
          check_field("applied_time", 64'(out_if.applied_time),
                      64'(want_res.applied_time));
          check_field("activation_stamp", 64'(out_if.activation_stamp),
                      64'(want_res.activation_stamp));
          check_field("acknowledge_stamp", 64'(out_if.acknowledge_stamp),
                      64'(want_res.acknowledge_stamp));
          check_field("clear_stamp", 64'(out_if.clear_stamp), 64'(want_res.clear_stamp));
          check_field("close_stamp", 64'(out_if.close_stamp), 64'(want_res.close_stamp));
          check_field("acknowledged_by_id", 64'(out_if.acknowledged_by_id),
                      64'(want_res.acknowledged_by_id));
          check_field("closed_by_id", 64'(out_if.closed_by_id),
                      64'(want_res.closed_by_id));
          check_field("occurrence_total", 64'(out_if.occurrence_total),
                      64'(want_res.occurrence_total));
        end
      end
      if (in_if.valid && in_if.ready) begin
        seen_req.operation = in_if.operation;
        seen_req.request_time = in_if.request_time;
        seen_req.current_time = in_if.current_time;
        seen_req.actor_id = in_if.actor_id;
        seen_req.actor_required = in_if.actor_required;
        expected_results.push_back(step_alarm(chk_rec, chk_ack, seen_req));
        items_accepted++;
      end
    end
  end

  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = OP_ACTIVATE;
    in_if.request_time = '0;
    in_if.current_time = '0;
    in_if.actor_id = '0;
    in_if.actor_required = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.ack_required = 1'b1;
    in_taken = 1'b0;
    gen_rec = '0;
    chk_rec = '0;
    gen_ack = 1'b1;
    chk_ack = 1'b1;
    items_queued = 0;
    items_accepted = 0;
    mismatches = 0;
    set_idling(0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_op(OP_ACKNOWLEDGE, 48'd5, 48'd6, '0, 1'b1);
    push_op(op_t'(15), '1, '1, '1, 1'b1);
    push_op(op_t'(9), 48'd1, 48'd2, 16'd3, 1'b0);
    push_op(OP_CLOSE, 48'd7, 48'd8, 16'd9, 1'b1);
    push_op(OP_UNSHELVE, 48'd7, 48'd8, 16'd9, 1'b0);
    push_op(OP_REACTIVATE, 48'd7, 48'd8, 16'd9, 1'b0);
    push_op(OP_ACTIVATE, '0, '1, '0, 1'b0);
    push_op(OP_ACTIVATE, 48'd10, 48'd11, 16'd1, 1'b0);
    push_op(OP_ACKNOWLEDGE, '1, 48'd1, '1, 1'b1);
    push_op(OP_ACKNOWLEDGE, 48'd12, 48'd13, 16'd2, 1'b1);
    push_op(OP_SHELVE, '0, '0, 16'd4, 1'b1);
    push_op(OP_UNSHELVE, 48'd123, 48'd124, 16'd5, 1'b0);
    push_op(OP_SUPPRESS, 48'h8000_0000_0000, 48'd1, 16'h8000, 1'b1);
    push_op(OP_UNSUPPRESS, '0, 48'h7FFF_FFFF_FFFF, 16'd6, 1'b0);
    push_op(OP_ACKNOWLEDGE, 48'd200, 48'd201, '0, 1'b0);
    push_op(OP_CLEAR, '0, '0, 16'd7, 1'b0);
    push_op(OP_ACKNOWLEDGE, 48'd300, 48'd301, 16'd8, 1'b1);
    push_op(OP_SHELVE, 48'd302, 48'd303, 16'd8, 1'b0);
    push_op(OP_REACTIVATE, 48'h5555_5555_5555, 48'd1, 16'h5555, 1'b1);
    push_op(OP_CLEAR, 48'hAAAA_AAAA_AAAA, 48'd2, 16'hAAAA, 1'b1);
    push_op(OP_CLOSE, 48'd400, 48'd401, '0, 1'b1);
    push_op(op_t'(10), 48'd500, 48'd501, 16'd1, 1'b0);
    push_op(OP_REACTIVATE, '0, 48'd600, 16'd1, 1'b0);
    push_op(OP_SUPPRESS, 48'd700, 48'd701, 16'd1, 1'b0);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      write_ack_required(1'(phase ^ (phase >> 2)));
      set_idling(phase % 4);
      if (!gen_ack) push_op(OP_ACKNOWLEDGE, rand_time(), rand_time(), 16'd42, 1'b1);
      for (int n = 0; n < PHASE_ITEMS; n++) queue_request(random_request($urandom_range(99) < 75));
      wait_drained();
    end

    // Raise the occurrence count with a run of reactivate/clear pairs.
    set_idling(0);
    route_to_cleared();
    repeat (10) begin
      push_op(OP_REACTIVATE, rand_time(), rand_time(), AW'($urandom_range(65535, 1)), 1'b1);
      push_op(OP_CLEAR, rand_time(), rand_time(), rand_actor(), 1'b0);
    end
    repeat (2) begin
      push_op(OP_REACTIVATE, rand_time(), rand_time(), rand_actor(), 1'b0);
      push_op(OP_CLEAR, rand_time(), rand_time(), rand_actor(), 1'b0);
    end
    wait_drained();

    write_ack_required(1'b1);
    set_idling(3);
    for (int n = 0; n < 20; n++) queue_request(random_request(1'b1));
    route_to_cleared();
    push_op(OP_CLOSE, rand_time(), rand_time(), '0, 1'b1);
    if ($urandom_range(1))
      push_op(OP_CLOSE, rand_time(), rand_time(), AW'($urandom_range(65535, 1)), 1'b1);
    else
      push_op(OP_CLOSE, rand_time(), rand_time(), '0, 1'b0);
    for (int n = 0; n < 24; n++) queue_request(random_request(1'b0));
    push_op(OP_ACTIVATE, rand_time(), rand_time(), '0, 1'b1);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
